FILE: hw/rtl/mdet_pkg.sv
// shared types, constants and step program for the 4x4 determinant core
`default_nettype none

package mdet_pkg;

  // matrix geometry
  localparam int MAX_DIM   = 4;
  localparam int STORE_DEP = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = 4;
  localparam int CNT_W     = 5;
  localparam int DIM_W     = 3;

  // datapath widths
  localparam int ELEM_W = 16;
  localparam int SCR_W  = 49;   // 3x3 minor of Q8.8 elements
  localparam int PROD_W = ELEM_W + SCR_W;
  localparam int ACC_W  = 67;   // full 4x4 determinant
  localparam int DET_W  = 64;

  // scratch file: six 2x2 minors, then four 3x3 minors
  localparam int NUM_SCR = 10;
  localparam int SIDX_W  = 4;
  localparam logic [SIDX_W-1:0] SCR_RES = 4'd15;

  // step program
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'd27;

  localparam logic [DIM_W-1:0]  DIM_RESET = 3'd4;
  localparam logic [DIM_W-1:0]  DIM_MAX   = 3'd4;
  localparam logic [DIM_W-1:0]  DIM_MIN   = 3'd1;
  localparam logic signed [ELEM_W-1:0] ONE_Q88 = 16'sd256;
  localparam logic signed [DET_W-1:0]  DET_POS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [DET_W-1:0]  DET_NEG_MAX = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH_A,
    ST_FETCH_B,
    ST_WAIT
  } mdet_state_e;

  // one multiply-accumulate step
  typedef struct packed {
    logic [1:0]        a_r;
    logic [1:0]        a_c;
    logic              b_scr;
    logic [1:0]        b_r;
    logic [1:0]        b_c;
    logic [SIDX_W-1:0] b_idx;
    logic              neg;
    logic              first;
    logic              last;
    logic [SIDX_W-1:0] dst;
  } mdet_uop_t;

  // controller to datapath
  typedef struct packed {
    logic              store_we;
    logic [ADDR_W-1:0] store_addr;
    logic              fetch_a;
    logic              fetch_b;
    logic [STEP_W-1:0] step;
  } mdet_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
  } mdet_sts_t;

  function automatic mdet_uop_t mk(
    input logic [1:0]        a_r,
    input logic [1:0]        a_c,
    input logic              b_scr,
    input logic [1:0]        b_r,
    input logic [1:0]        b_c,
    input logic [SIDX_W-1:0] b_idx,
    input logic              neg,
    input logic              first,
    input logic              last,
    input logic [SIDX_W-1:0] dst
  );
    mdet_uop_t u;
    u.a_r   = a_r;
    u.a_c   = a_c;
    u.b_scr = b_scr;
    u.b_r   = b_r;
    u.b_c   = b_c;
    u.b_idx = b_idx;
    u.neg   = neg;
    u.first = first;
    u.last  = last;
    u.dst   = dst;
    return u;
  endfunction

  // expansion program: 2x2 minors of rows 2-3, 3x3 minors of rows 1-3, row 0
  function automatic mdet_uop_t uop_at(input logic [STEP_W-1:0] step);
    mdet_uop_t u;
    unique case (step)
      // 2x2 minors, columns (0,1) (0,2) (0,3) (1,2) (1,3) (2,3)
      5'd0:  u = mk(2'd2, 2'd0, 1'b0, 2'd3, 2'd1, 4'd0, 1'b0, 1'b1, 1'b0, 4'd0);
      5'd1:  u = mk(2'd3, 2'd0, 1'b0, 2'd2, 2'd1, 4'd0, 1'b1, 1'b0, 1'b1, 4'd0);
      5'd2:  u = mk(2'd2, 2'd0, 1'b0, 2'd3, 2'd2, 4'd0, 1'b0, 1'b1, 1'b0, 4'd0);
      5'd3:  u = mk(2'd3, 2'd0, 1'b0, 2'd2, 2'd2, 4'd0, 1'b1, 1'b0, 1'b1, 4'd1);
      5'd4:  u = mk(2'd2, 2'd0, 1'b0, 2'd3, 2'd3, 4'd0, 1'b0, 1'b1, 1'b0, 4'd0);
      5'd5:  u = mk(2'd3, 2'd0, 1'b0, 2'd2, 2'd3, 4'd0, 1'b1, 1'b0, 1'b1, 4'd2);
      5'd6:  u = mk(2'd2, 2'd1, 1'b0, 2'd3, 2'd2, 4'd0, 1'b0, 1'b1, 1'b0, 4'd0);
      5'd7:  u = mk(2'd3, 2'd1, 1'b0, 2'd2, 2'd2, 4'd0, 1'b1, 1'b0, 1'b1, 4'd3);
      5'd8:  u = mk(2'd2, 2'd1, 1'b0, 2'd3, 2'd3, 4'd0, 1'b0, 1'b1, 1'b0, 4'd0);
      5'd9:  u = mk(2'd3, 2'd1, 1'b0, 2'd2, 2'd3, 4'd0, 1'b1, 1'b0, 1'b1, 4'd4);
      5'd10: u = mk(2'd2, 2'd2, 1'b0, 2'd3, 2'd3, 4'd0, 1'b0, 1'b1, 1'b0, 4'd0);
      5'd11: u = mk(2'd3, 2'd2, 1'b0, 2'd2, 2'd3, 4'd0, 1'b1, 1'b0, 1'b1, 4'd5);
      // 3x3 minor without column 0; the newest 2x2 minor is read late
      5'd12: u = mk(2'd1, 2'd3, 1'b1, 2'd0, 2'd0, 4'd3, 1'b0, 1'b1, 1'b0, 4'd0);
      5'd13: u = mk(2'd1, 2'd1, 1'b1, 2'd0, 2'd0, 4'd5, 1'b0, 1'b0, 1'b0, 4'd0);
      5'd14: u = mk(2'd1, 2'd2, 1'b1, 2'd0, 2'd0, 4'd4, 1'b1, 1'b0, 1'b1, 4'd6);
      // without column 1
      5'd15: u = mk(2'd1, 2'd3, 1'b1, 2'd0, 2'd0, 4'd1, 1'b0, 1'b1, 1'b0, 4'd0);
      5'd16: u = mk(2'd1, 2'd0, 1'b1, 2'd0, 2'd0, 4'd5, 1'b0, 1'b0, 1'b0, 4'd0);
      5'd17: u = mk(2'd1, 2'd2, 1'b1, 2'd0, 2'd0, 4'd2, 1'b1, 1'b0, 1'b1, 4'd7);
      // without column 2
      5'd18: u = mk(2'd1, 2'd3, 1'b1, 2'd0, 2'd0, 4'd0, 1'b0, 1'b1, 1'b0, 4'd0);
      5'd19: u = mk(2'd1, 2'd0, 1'b1, 2'd0, 2'd0, 4'd4, 1'b0, 1'b0, 1'b0, 4'd0);
      5'd20: u = mk(2'd1, 2'd1, 1'b1, 2'd0, 2'd0, 4'd2, 1'b1, 1'b0, 1'b1, 4'd8);
      // without column 3
      5'd21: u = mk(2'd1, 2'd2, 1'b1, 2'd0, 2'd0, 4'd0, 1'b0, 1'b1, 1'b0, 4'd0);
      5'd22: u = mk(2'd1, 2'd0, 1'b1, 2'd0, 2'd0, 4'd3, 1'b0, 1'b0, 1'b0, 4'd0);
      5'd23: u = mk(2'd1, 2'd1, 1'b1, 2'd0, 2'd0, 4'd1, 1'b1, 1'b0, 1'b1, 4'd9);
      // first row against the 3x3 minors
      5'd24: u = mk(2'd0, 2'd0, 1'b1, 2'd0, 2'd0, 4'd6, 1'b0, 1'b1, 1'b0, 4'd0);
      5'd25: u = mk(2'd0, 2'd1, 1'b1, 2'd0, 2'd0, 4'd7, 1'b1, 1'b0, 1'b0, 4'd0);
      5'd26: u = mk(2'd0, 2'd2, 1'b1, 2'd0, 2'd0, 4'd8, 1'b0, 1'b0, 1'b0, 4'd0);
      5'd27: u = mk(2'd0, 2'd3, 1'b1, 2'd0, 2'd0, 4'd9, 1'b1, 1'b0, 1'b1, SCR_RES);
      default: u = mk(2'd0, 2'd0, 1'b0, 2'd0, 2'd0, 4'd0, 1'b0, 1'b0, 1'b0, 4'd0);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/matrix_determinant_4x4_core.sv
// 4x4 determinant core: the completing word of a matrix starts the expansion
// elements load one per cycle while busy_o is low; the expansion runs 28 multiply
// steps, each a fetch-A then a fetch-B state, via one shared 16x49 multiplier and a 67-bit accumulator
// busy_o rises after the completing word and falls after the done_o strobe; no element loads while it is high
// done_o strobes the result for one cycle; the receiver cannot stall it
// reset clears the counter, sets the dimension to 4; the store needs no clear
`default_nettype none

module matrix_determinant_4x4_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic signed [mdet_pkg::ELEM_W-1:0]  element_value_i,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [mdet_pkg::DIM_W-1:0]          cfg_data_i,
  output logic                                     done_o,
  output logic signed [mdet_pkg::DET_W-1:0]        determinant_o,
  output logic                                     saturated_o
);

  mdet_pkg::mdet_cmd_t        cmd;
  mdet_pkg::mdet_sts_t        sts;
  logic [mdet_pkg::DIM_W-1:0] dim;

  // control
  mdet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .sts_i       (sts),
    .cfg_ready_o (cfg_ready_o),
    .busy_o      (busy_o),
    .dim_o       (dim),
    .cmd_o       (cmd)
  );

  // arithmetic
  mdet_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .dim_i           (dim),
    .element_value_i (element_value_i),
    .sts_o           (sts),
    .determinant_o   (determinant_o),
    .saturated_o     (saturated_o)
  );

  assign done_o = sts.done;

endmodule

`default_nettype wire

FILE: hw/rtl/mdet_ctrl.sv
// controller: dimension register, element counter and step sequencer
`default_nettype none

module mdet_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic                            cfg_valid_i,
  input  wire logic [mdet_pkg::DIM_W-1:0]      cfg_data_i,
  input  wire mdet_pkg::mdet_sts_t             sts_i,
  output logic                                 cfg_ready_o,
  output logic                                 busy_o,
  output logic [mdet_pkg::DIM_W-1:0]           dim_o,
  output mdet_pkg::mdet_cmd_t                  cmd_o
);

  mdet_pkg::mdet_state_e state_q, state_d;
  logic [mdet_pkg::DIM_W-1:0]  dim_q;
  logic [mdet_pkg::CNT_W-1:0]  count_q, count_d;
  logic [mdet_pkg::STEP_W-1:0] step_q, step_d;
  logic [mdet_pkg::DIM_W-1:0]  dim_eff;
  logic [mdet_pkg::CNT_W-1:0]  total;
  logic [mdet_pkg::CNT_W-1:0]  cur;
  logic [mdet_pkg::CNT_W-1:0]  nxt;
  logic                        accept;
  logic                        cfg_wr;
  logic                        complete;

  // effective size: zero acts as one, above the maximum clamps
  always_comb begin
    if (dim_q == '0) begin
      dim_eff = mdet_pkg::DIM_MIN;
    end else if (dim_q > mdet_pkg::DIM_MAX) begin
      dim_eff = mdet_pkg::DIM_MAX;
    end else begin
      dim_eff = dim_q;
    end
  end

  assign total    = 5'({2'b00, dim_eff} * {2'b00, dim_eff});
  assign accept   = start_i && (state_q == mdet_pkg::ST_IDLE);
  assign cfg_wr   = cfg_valid_i && cfg_ready_o;
  assign cur      = (count_q >= total) ? '0 : count_q;
  assign nxt      = cur + 5'd1;
  assign complete = accept && (nxt == total);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mdet_pkg::ST_IDLE: begin
        if (complete) state_d = mdet_pkg::ST_FETCH_A;
      end
      mdet_pkg::ST_FETCH_A: begin
        state_d = mdet_pkg::ST_FETCH_B;
      end
      mdet_pkg::ST_FETCH_B: begin
        if (step_q == mdet_pkg::LAST_STEP) begin
          state_d = mdet_pkg::ST_WAIT;
        end else begin
          state_d = mdet_pkg::ST_FETCH_A;
        end
      end
      mdet_pkg::ST_WAIT: begin
        if (sts_i.done) state_d = mdet_pkg::ST_IDLE;
      end
      default: state_d = mdet_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.store_we   = accept;
    cmd_o.store_addr = cur[mdet_pkg::ADDR_W-1:0];
    cmd_o.fetch_a    = 1'b0;
    cmd_o.fetch_b    = 1'b0;
    cmd_o.step       = step_q;
    busy_o           = 1'b1;
    unique case (state_q)
      mdet_pkg::ST_IDLE:    busy_o = 1'b0;
      mdet_pkg::ST_FETCH_A: cmd_o.fetch_a = 1'b1;
      mdet_pkg::ST_FETCH_B: cmd_o.fetch_b = 1'b1;
      mdet_pkg::ST_WAIT:    busy_o = 1'b1;
      default:              busy_o = 1'b1;
    endcase
  end

  assign cfg_ready_o = (state_q == mdet_pkg::ST_IDLE);
  assign dim_o       = dim_eff;

  // element counter
  always_comb begin
    count_d = count_q;
    if (cfg_wr) begin
      count_d = '0;
    end else if (accept) begin
      count_d = complete ? '0 : nxt;
    end
  end

  // step counter
  always_comb begin
    step_d = step_q;
    if (complete) begin
      step_d = '0;
    end else if (state_q == mdet_pkg::ST_FETCH_B) begin
      step_d = step_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mdet_pkg::ST_IDLE;
      dim_q   <= mdet_pkg::DIM_RESET;
      count_q <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
      if (cfg_wr) dim_q <= cfg_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mdet_datapath.sv
// datapath: element store, minor scratch file, multiply-accumulate, saturation
`default_nettype none

module mdet_datapath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire mdet_pkg::mdet_cmd_t                  cmd_i,
  input  wire logic [mdet_pkg::DIM_W-1:0]           dim_i,
  input  wire logic signed [mdet_pkg::ELEM_W-1:0]   element_value_i,
  output mdet_pkg::mdet_sts_t                       sts_o,
  output logic signed [mdet_pkg::DET_W-1:0]         determinant_o,
  output logic                                      saturated_o
);

  // stage control carried with each multiply
  typedef struct packed {
    logic                        valid;
    logic                        neg;
    logic                        first;
    logic                        last;
    logic [mdet_pkg::SIDX_W-1:0] dst;
  } mdet_stg_t;

  logic signed [mdet_pkg::ELEM_W-1:0] store_q [mdet_pkg::STORE_DEP];
  logic signed [mdet_pkg::SCR_W-1:0]  scr_q   [mdet_pkg::NUM_SCR];

  mdet_pkg::mdet_uop_t uop;
  logic [1:0]                         rd_r;
  logic [1:0]                         rd_c;
  logic [4:0]                         lin;
  logic                               in_blk;
  logic signed [mdet_pkg::ELEM_W-1:0] elem;

  logic signed [mdet_pkg::ELEM_W-1:0] a_q;
  logic signed [mdet_pkg::SCR_W-1:0]  b_q;
  logic signed [mdet_pkg::PROD_W-1:0] prod_q;
  logic signed [mdet_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic signed [mdet_pkg::ACC_W-1:0]  prod_ext;
  mdet_stg_t                          stg1_q, stg2_q;
  logic                               done_q;
  logic                               ovf;
  logic                               fin;

  assign uop = mdet_pkg::uop_at(cmd_i.step);

  // element fetch: the matrix padded to 4x4 with ones on the diagonal
  assign rd_r   = cmd_i.fetch_b ? uop.b_r : uop.a_r;
  assign rd_c   = cmd_i.fetch_b ? uop.b_c : uop.a_c;
  assign lin    = 5'({3'b000, rd_r} * {2'b00, dim_i}) + {3'b000, rd_c};
  assign in_blk = ({1'b0, rd_r} < dim_i) && ({1'b0, rd_c} < dim_i);

  always_comb begin
    if (in_blk) begin
      elem = store_q[lin[mdet_pkg::ADDR_W-1:0]];
    end else if (rd_r == rd_c) begin
      elem = mdet_pkg::ONE_Q88;
    end else begin
      elem = '0;
    end
  end

  // element store write
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_we) store_q[cmd_i.store_addr] <= element_value_i;
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch_a) a_q <= elem;
    if (cmd_i.fetch_b) begin
      if (uop.b_scr) begin
        b_q <= scr_q[uop.b_idx];
      end else begin
        b_q <= {{(mdet_pkg::SCR_W-mdet_pkg::ELEM_W){elem[mdet_pkg::ELEM_W-1]}}, elem};
      end
    end
  end

  // multiply stage
  always_ff @(posedge clk_i) begin
    prod_q <= a_q * b_q;
  end

  // accumulate
  assign prod_ext = {{(mdet_pkg::ACC_W-mdet_pkg::PROD_W){prod_q[mdet_pkg::PROD_W-1]}}, prod_q};

  always_comb begin
    acc_d = stg2_q.first ? '0 : acc_q;
    if (stg2_q.neg) begin
      acc_d = acc_d - prod_ext;
    end else begin
      acc_d = acc_d + prod_ext;
    end
  end

  assign fin = stg2_q.valid && stg2_q.last && (stg2_q.dst == mdet_pkg::SCR_RES);
  assign ovf = !((acc_d[mdet_pkg::ACC_W-1:mdet_pkg::DET_W-1] == '0) ||
                 (acc_d[mdet_pkg::ACC_W-1:mdet_pkg::DET_W-1] == '1));

  always_ff @(posedge clk_i) begin
    if (stg2_q.valid) acc_q <= acc_d;
    if (stg2_q.valid && stg2_q.last && (stg2_q.dst != mdet_pkg::SCR_RES)) begin
      scr_q[stg2_q.dst] <= acc_d[mdet_pkg::SCR_W-1:0];
    end
  end

  // result word with saturation
  always_ff @(posedge clk_i) begin
    if (fin) begin
      saturated_o <= ovf;
      if (!ovf) begin
        determinant_o <= acc_d[mdet_pkg::DET_W-1:0];
      end else if (acc_d[mdet_pkg::ACC_W-1]) begin
        determinant_o <= mdet_pkg::DET_NEG_MAX;
      end else begin
        determinant_o <= mdet_pkg::DET_POS_MAX;
      end
    end
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg1_q <= '0;
      stg2_q <= '0;
      done_q <= 1'b0;
    end else begin
      stg1_q.valid <= cmd_i.fetch_b;
      stg1_q.neg   <= uop.neg;
      stg1_q.first <= uop.first;
      stg1_q.last  <= uop.last;
      stg1_q.dst   <= uop.dst;
      stg2_q       <= stg1_q;
      done_q       <= fin;
    end
  end

  assign sts_o.done = done_q;

endmodule

`default_nettype wire
